// ===== rtl/bernstein_tensor_deform_defines.svh =====
// assertion macros for the bernstein deformation block
// used by the top level only
`ifndef BERNSTEIN_TENSOR_DEFORM_DEFINES_SVH
`define BERNSTEIN_TENSOR_DEFORM_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BTD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BTD_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTD_ASSERT(lbl, clk, rst, prop, msg)
`define BTD_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/btd_pkg.sv =====
// shared types, constants and helpers for the bernstein deformation block
// no dependencies
package btd_pkg;
  localparam int M = 8;
  localparam int IW = $clog2(M);
  localparam int AW = 3 * IW;
  localparam int FRAC_BITS = 16;
  localparam int CW = 4;
  localparam logic [1:0] REG_U = 2'd0;
  localparam logic [1:0] REG_V = 2'd1;
  localparam logic [1:0] REG_W = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BASIS, ST_WEIGHT, ST_MAC, ST_DONE
  } state_t;

  typedef struct packed {
    logic start_basis;
    logic basis_step;
    logic clear_acc;
    logic wij_load;
    logic mac_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic basis_done;
    logic mac_last;
    logic wk_last;
    logic acc_busy;
  } status_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // rounded product, ties toward +inf, arithmetic shift is floor
  function automatic logic signed [63:0] mulw(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic [CW-1:0] eff(input logic [CW-1:0] c);
    if (c == '0) return CW'(1);
    if (c > CW'(M)) return CW'(M);
    return c;
  endfunction

  // binomial C(n,k) for n < M, constant table
  function automatic logic [7:0] binom(input logic [IW-1:0] n, input logic [IW-1:0] k);
    logic [7:0] row [M];
    for (int i = 0; i < M; i++) row[i] = 8'd0;
    row[0] = 8'd1;
    for (int r = 1; r < M; r++)
      if (r <= int'(n))
        for (int i = M - 1; i >= 1; i--) row[i] = row[i] + row[i-1];
    if (k > n) return 8'd0;
    return row[k];
  endfunction
endpackage

// ===== rtl/btd_ctrl.sv =====
// controller fsm for the bernstein deformation block
// depends on btd_pkg
module btd_ctrl import btd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    out_free,
  input  status_t st,
  output cmd_t    cmd,
  output logic    busy
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_BASIS;
      ST_BASIS:  if (st.basis_done) state_next = ST_WEIGHT;
      ST_WEIGHT: state_next = ST_MAC;
      ST_MAC: begin
        if (st.mac_last) state_next = ST_DONE;
        else if (st.wk_last) state_next = ST_WEIGHT;
      end
      // wait for the last product to land in the accumulators
      ST_DONE:   if (out_free && !st.acc_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.start_basis = start;
        cmd.clear_acc = start;
      end
      ST_BASIS:  cmd.basis_step = 1'b1;
      ST_WEIGHT: cmd.wij_load = 1'b1;
      ST_MAC:    cmd.mac_step = 1'b1;
      ST_DONE:   cmd.out_load = out_free && !st.acc_busy;
      default:   cmd = '0;
    endcase
  end
endmodule

// ===== rtl/btd_dp.sv =====
// datapath: basis units, weight products, store and accumulators
// depends on btd_pkg
module btd_dp import btd_pkg::*; (
  input  logic               clk,
  input  cmd_t               cmd,
  input  logic               ld_en,
  input  logic [AW-1:0]      ld_addr,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic [CW-1:0]      nu,
  input  logic [CW-1:0]      nv,
  input  logic [CW-1:0]      nw,
  output status_t            st,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);
  logic signed [31:0] mem_x [M*M*M];
  logic signed [31:0] mem_y [M*M*M];
  logic signed [31:0] mem_z [M*M*M];
  logic signed [31:0] rd_x, rd_y, rd_z;

  logic signed [31:0] tv [3];
  logic signed [31:0] omt [3];
  logic [IW:0] n [3];
  logic signed [31:0] bas [3][M];
  logic signed [31:0] cur [3];
  logic [IW-1:0] bi;
  logic [IW:0] be;
  logic [IW-1:0] ci, cj, ck;
  logic [IW-1:0] pi, pj;
  logic signed [31:0] wij, wt;
  logic rd_v;
  logic signed [63:0] ax, ay, az;
  logic mac_last, wk_last;

  always_ff @(posedge clk) begin
    if (ld_en) begin
      mem_x[ld_addr] <= in_x;
      mem_y[ld_addr] <= in_y;
      mem_z[ld_addr] <= in_z;
    end
    rd_x <= mem_x[{pi, pj, ck}];
    rd_y <= mem_y[{pi, pj, ck}];
    rd_z <= mem_z[{pi, pj, ck}];
  end

  // basis: one mul per axis per cycle; term bi, exponent step be
  always_ff @(posedge clk) begin
    if (cmd.start_basis) begin
      tv[0] <= in_x; tv[1] <= in_y; tv[2] <= in_z;
      n[0] <= (IW+1)'(nu); n[1] <= (IW+1)'(nv); n[2] <= (IW+1)'(nw);
      for (int a = 0; a < 3; a++) cur[a] <= 32'sd1 <<< FRAC_BITS;
      omt[0] <= sat32((64'sd1 <<< FRAC_BITS) - 64'(in_x));
      omt[1] <= sat32((64'sd1 <<< FRAC_BITS) - 64'(in_y));
      omt[2] <= sat32((64'sd1 <<< FRAC_BITS) - 64'(in_z));
      bi <= '0;
      be <= '0;
    end else if (cmd.basis_step) begin
      for (int a = 0; a < 3; a++) begin
        if (be == (IW+1)'(M - 1)) begin
          bas[a][bi] <= (32'(bi) < 32'(n[a])) ?
            sat32(64'(cur[a]) * 64'($signed({1'b0, binom(IW'(n[a] - 1'b1), bi)})))
            : 32'sd0;
          cur[a] <= 32'sd1 <<< FRAC_BITS;
        end else if (be < (IW+1)'(bi)) begin
          cur[a] <= sat32(mulw(cur[a], tv[a]));
        end else if (32'(be) < 32'(n[a]) - 1) begin
          cur[a] <= sat32(mulw(cur[a], omt[a]));
        end
      end
      if (be == (IW+1)'(M - 1)) begin
        be <= '0;
        bi <= bi + 1'b1;
      end else begin
        be <= be + 1'b1;
      end
    end
  end
  assign st.basis_done = cmd.basis_step && (be == (IW+1)'(M - 1)) && (bi == IW'(M - 1));

  // mac walk over (i,j,k): address, then weight, then accumulate
  assign wk_last = (ck == IW'(nw - 1'b1));
  assign mac_last = wk_last && (cj == IW'(nv - 1'b1)) && (ci == IW'(nu - 1'b1));
  assign st.wk_last = wk_last;
  assign st.mac_last = mac_last;
  assign st.acc_busy = rd_v;

  always_ff @(posedge clk) begin
    if (cmd.start_basis) begin
      ci <= '0; cj <= '0; ck <= '0;
    end
    if (cmd.wij_load) begin
      wij <= sat32(mulw(bas[0][ci], bas[1][cj]));
      pi <= ci; pj <= cj; ck <= '0;
    end
    rd_v <= cmd.mac_step;
    if (cmd.mac_step) begin
      wt <= sat32(mulw(wij, bas[2][ck]));
      if (wk_last) begin
        ck <= '0;
        if (cj == IW'(nv - 1'b1)) begin
          cj <= '0; ci <= ci + 1'b1;
        end else begin
          cj <= cj + 1'b1;
        end
      end else begin
        ck <= ck + 1'b1;
      end
    end
    if (cmd.clear_acc) begin
      ax <= '0; ay <= '0; az <= '0;
    end else if (rd_v) begin
      ax <= ax + mulw(wt, rd_x);
      ay <= ay + mulw(wt, rd_y);
      az <= az + mulw(wt, rd_z);
    end
  end

  assign res_x = sat32(ax);
  assign res_y = sat32(ay);
  assign res_z = sat32(az);
endmodule

// ===== rtl/bernstein_tensor_deform.sv =====
// top level: stream ports, config registers, controller and datapath
// depends on btd_pkg, btd_ctrl, btd_dp and the defines header
`include "bernstein_tensor_deform_defines.svh"
module bernstein_tensor_deform import btd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: lattice_u[2:0], lattice_v[5:3], lattice_w[8:6], coord_x[40:9],
  // coord_y[72:41], coord_z[104:73], zero fill to 112
  input  logic [111:0] s_tdata,
  input  logic         s_tuser,   // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,   // out_x[31:0], out_y[63:32], out_z[95:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [3:0]   cfg_data
);
  // a deform shows its result after the basis steps, the walk over the lattice
  // (a weight load and nw products per (i,j)), the accumulator drain and the result load
  // a load is written on its transfer; one item at a time, the next is taken in the cycle
  // after the result is registered; a waiting result holds off the next deform
  // reset clears the counts to 4 and the control; the store is not cleared
  logic [CW-1:0] u_count, v_count, w_count;
  cmd_t cmd;
  status_t st;
  logic busy, start, out_free;
  logic signed [31:0] rx, ry, rz;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      u_count <= CW'(4); v_count <= CW'(4); w_count <= CW'(4);
    end else if (cfg_valid) begin
      if (cfg_index == REG_U) u_count <= cfg_data;
      if (cfg_index == REG_V) v_count <= cfg_data;
      if (cfg_index == REG_W) w_count <= cfg_data;
    end
  end

  assign s_tready = !busy;
  assign start = s_tvalid && s_tready && s_tuser;
  assign out_free = !m_tvalid || m_tready;

  btd_ctrl u_ctrl (.clk, .rst, .start, .out_free, .st, .cmd, .busy);

  // store address is (u*M + v)*M + w
  btd_dp u_dp (
    .clk, .cmd,
    .ld_en(s_tvalid && s_tready && !s_tuser),
    .ld_addr({s_tdata[2:0], s_tdata[5:3], s_tdata[8:6]}),
    .in_x(s_tdata[40:9]), .in_y(s_tdata[72:41]), .in_z(s_tdata[104:73]),
    .nu(eff(u_count)), .nv(eff(v_count)), .nw(eff(w_count)),
    .st, .res_x(rx), .res_y(ry), .res_z(rz)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) m_tdata <= {rz, ry, rx};
  end

  `BTD_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
  `BTD_ASSERT(a_no_take_busy, clk, rst, busy |-> !s_tready, "accept while busy")
  `BTD_ASSERT_RST(a_rst_idle, clk, rst |=> !m_tvalid, "valid after reset")
endmodule

// ===== tb/btd_checker.sv =====
// checker for the bernstein deformation block: watches the config, input and result channels
// keeps its own lattice copy and counts, predicts each deformed point and compares
// depends on btd_pkg
module btd_checker import btd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [111:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [3:0]   cfg_data,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_t;

  logic [31:0] lat_x [512];
  logic [31:0] lat_y [512];
  logic [31:0] lat_z [512];
  logic [3:0]  cnt_u, cnt_v, cnt_w;
  point_t      deformed_q [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // rounded fixed-point product, ties toward +inf, no clamp
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic int axis_count(input logic [3:0] c);
    if (c == 4'd0) return 1;
    if (c > 4'd8) return 8;
    return int'(c);
  endfunction

  function automatic longint choose(input int n, input int k);
    longint c;
    c = 1;
    for (int i = 1; i <= k; i++) c = c * (n - k + i) / i;
    return c;
  endfunction

  function automatic longint bern(input int n, input int i, input longint t);
    longint v, omt;
    omt = clamp32(64'sd65536 - t);
    v = 64'sd65536;
    for (int e = 0; e < i; e++) v = clamp32(fx_mul(v, t));
    for (int e = 0; e < n - 1 - i; e++) v = clamp32(fx_mul(v, omt));
    return clamp32(v * choose(n - 1, i));
  endfunction

  function automatic point_t deform_point(input logic signed [31:0] tu,
                                          input logic signed [31:0] tv,
                                          input logic signed [31:0] tw);
    longint bu [8];
    longint bv [8];
    longint bw [8];
    longint ax, ay, az, wij, wt;
    int nu, nv, nw, a;
    point_t r;
    nu = axis_count(cnt_u);
    nv = axis_count(cnt_v);
    nw = axis_count(cnt_w);
    for (int i = 0; i < 8; i++) begin
      bu[i] = (i < nu) ? bern(nu, i, longint'(tu)) : 0;
      bv[i] = (i < nv) ? bern(nv, i, longint'(tv)) : 0;
      bw[i] = (i < nw) ? bern(nw, i, longint'(tw)) : 0;
    end
    ax = 0; ay = 0; az = 0;
    for (int i = 0; i < nu; i++)
      for (int j = 0; j < nv; j++) begin
        wij = clamp32(fx_mul(bu[i], bv[j]));
        for (int k = 0; k < nw; k++) begin
          wt = clamp32(fx_mul(wij, bw[k]));
          a = (i * 8 + j) * 8 + k;
          ax += fx_mul(wt, longint'($signed(lat_x[a])));
          ay += fx_mul(wt, longint'($signed(lat_y[a])));
          az += fx_mul(wt, longint'($signed(lat_z[a])));
        end
      end
    r.x = 32'(clamp32(ax));
    r.y = 32'(clamp32(ay));
    r.z = 32'(clamp32(az));
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
    for (int i = 0; i < 512; i++) begin
      lat_x[i] = '0; lat_y[i] = '0; lat_z[i] = '0;
    end
  end

  always @(posedge clk) begin
    point_t got, want;
    int a;
    if (rst) begin
      cnt_u <= 4'd4; cnt_v <= 4'd4; cnt_w <= 4'd4;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (deformed_q.size() == 0) begin
          $error("result transfer with no deform outstanding: %h", m_tdata);
          fail_count++;
        end else begin
          want = deformed_q.pop_front();
          if (got.x !== want.x) begin
            $error("out_x expected %h actual %h", want.x, got.x); fail_count++;
          end
          if (got.y !== want.y) begin
            $error("out_y expected %h actual %h", want.y, got.y); fail_count++;
          end
          if (got.z !== want.z) begin
            $error("out_z expected %h actual %h", want.z, got.z); fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_U) cnt_u <= cfg_data;
        else if (cfg_index == REG_V) cnt_v <= cfg_data;
        else if (cfg_index == REG_W) cnt_w <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (!s_tuser) begin
          a = (int'(s_tdata[2:0]) * 8 + int'(s_tdata[5:3])) * 8 + int'(s_tdata[8:6]);
          lat_x[a] = s_tdata[40:9];
          lat_y[a] = s_tdata[72:41];
          lat_z[a] = s_tdata[104:73];
        end else begin
          deformed_q.push_back(deform_point(s_tdata[40:9], s_tdata[72:41],
                                            s_tdata[104:73]));
        end
      end
    end
    pending = deformed_q.size();
  end
endmodule

// ===== tb/tb_top.sv =====
// stimulus and verdict for the bernstein deformation block
// depends on btd_pkg, bernstein_tensor_deform and btd_checker
module tb_top import btd_pkg::*;;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam logic LOAD = 1'b0;
  localparam logic DEFORM = 1'b1;

  logic         clk, rst;
  logic         s_tvalid, s_tready, s_tuser;
  logic [111:0] s_tdata;
  logic         m_tvalid, m_tready;
  logic [95:0]  m_tdata;
  logic         cfg_valid, cfg_ready;
  logic [1:0]   cfg_index;
  logic [3:0]   cfg_data;
  int           fail_count, pending;
  int           send_idle, recv_stall;
  int           n_loads, n_deforms;
  bit           written [512];
  logic [3:0]   cur_u, cur_v, cur_w;

  bernstein_tensor_deform u_top (.*);

  btd_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  function automatic int axis_count(input logic [3:0] c);
    if (c == 4'd0) return 1;
    if (c > 4'd8) return 8;
    return int'(c);
  endfunction

  task automatic send_item(input logic req, input int u, input int v, input int w,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = req;
    s_tdata = {7'd0, z, y, x, w[2:0], v[2:0], u[2:0]};
    do @(posedge clk); while (!s_tready);
    if (req == LOAD) begin
      written[(u * 8 + v) * 8 + w] = 1'b1;
      n_loads++;
    end else n_deforms++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    // a load leaves no result, so give it time to retire
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_U) cur_u = val;
    else if (idx == REG_V) cur_v = val;
    else if (idx == REG_W) cur_w = val;
  endtask

  task automatic set_counts(input logic [3:0] cu, input logic [3:0] cv, input logic [3:0] cw);
    go_quiet();
    write_reg(REG_U, cu);
    write_reg(REG_V, cv);
    write_reg(REG_W, cw);
    write_reg(REG_SPARE, 4'($urandom));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [31:0] rand_param();
    case ($urandom_range(11))
      0: return 32'h0;
      1: return 32'h10000;
      2: return 32'h8000;
      3: return $urandom;
      default: return 32'($signed($urandom_range(3 << 16)) - (1 << 16));
    endcase
  endfunction

  // every entry a deform can reach must be loaded first
  task automatic fill_box();
    for (int u = 0; u < axis_count(cur_u); u++)
      for (int v = 0; v < axis_count(cur_v); v++)
        for (int w = 0; w < axis_count(cur_w); w++)
          if (!written[(u * 8 + v) * 8 + w])
            send_item(LOAD, u, v, w, rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic deform(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    fill_box();
    send_item(DEFORM, $urandom_range(7), $urandom_range(7), $urandom_range(7), x, y, z);
  endtask

  logic [3:0] cfg_set [7][3] = '{'{4, 4, 4}, '{0, 1, 15}, '{8, 8, 8}, '{1, 8, 2},
                                 '{3, 5, 7}, '{15, 0, 8}, '{2, 2, 2}};
  int phase_idle [4] = '{0, 71, 0, 25};
  int phase_stall [4] = '{0, 0, 71, 25};

  initial begin
    s_tvalid = 0; s_tuser = 0; s_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    m_tready = 0;
    send_idle = 0; recv_stall = 0;
    n_loads = 0; n_deforms = 0;
    cur_u = 4; cur_v = 4; cur_w = 4;
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extreme control points, then corner parameters
    send_item(LOAD, 0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h0);
    send_item(LOAD, 3, 3, 3, 32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_item(LOAD, 7, 7, 7, 32'h12345678, 32'hedcba987, 32'h00010000);
    deform(32'h0, 32'h0, 32'h0);
    deform(32'h10000, 32'h10000, 32'h10000);
    deform(32'h8000, 32'h8000, 32'h8000);
    deform(32'h7fffffff, 32'h80000000, 32'h0);
    deform(32'h80000000, 32'h7fffffff, 32'hffff0000);
    deform(32'h20000, 32'hffff0000, 32'h4000);
    send_item(LOAD, 1, 2, 3, 32'h0, 32'h0, 32'h0);
    deform(32'h5555, 32'haaaa, 32'hc000);
    set_counts(4'd0, 4'd15, 4'd8);
    deform(32'h8000, 32'h8000, 32'h8000);
    deform(32'h7fffffff, 32'h10000, 32'h0);

    for (int p = 0; p < 4; p++) begin
      send_idle = phase_idle[p];
      recv_stall = phase_stall[p];
      for (int c = 0; c < 7; c++) begin
        if (c == 6) set_counts(4'($urandom), 4'($urandom), 4'($urandom));
        else set_counts(cfg_set[c][0], cfg_set[c][1], cfg_set[c][2]);
        for (int n = 0; n < 22; n++) begin
          if ($urandom_range(3) == 0)
            send_item(LOAD, $urandom_range(7), $urandom_range(7), $urandom_range(7),
                      rand_coord(), rand_coord(), rand_coord());
          else deform(rand_param(), rand_param(), rand_param());
          if (p == 1 && c == 3 && n == 5) begin
            @(negedge clk);
            s_tvalid = 1'b0;
            wait (pending == 0);
          end
        end
      end
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending == 0);
    repeat (700) @(posedge clk);
    $display("covered %0d loads and %0d deforms over 29 count settings, four handshake mixes",
             n_loads, n_deforms);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/btd_pkg.sv
rtl/btd_ctrl.sv
rtl/btd_dp.sv
rtl/bernstein_tensor_deform.sv
tb/btd_checker.sv
tb/tb_top.sv
